// ===== sv/rexp_pkg.sv =====
// Rule expression tokenizer package: character codes, token and fault codes,
// result item and configuration types, and result-list helpers.
// No dependencies.
package rexp_pkg;

  localparam int unsigned ARITH_N  = 6;
  localparam int unsigned ARITH_W  = 8 * ARITH_N;
  localparam int unsigned CFG_W    = ARITH_W;
  localparam int unsigned CFG_IW   = 2;
  localparam int unsigned MAX_PUSH = 2;
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);
  localparam int unsigned TUSER_W  = 9;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;

  typedef enum logic [3:0] {
    KIND_ARITH   = 4'd0,
    KIND_BOOL    = 4'd1,
    KIND_COMPARE = 4'd2,
    KIND_STRING  = 4'd3,
    KIND_NUMBER  = 4'd4,
    KIND_LPAREN  = 4'd5,
    KIND_RPAREN  = 4'd6,
    KIND_IDENT   = 4'd7,
    KIND_SEP     = 4'd8,
    KIND_ARRAY   = 4'd9
  } kind_e;

  typedef enum logic [2:0] {
    FLT_NONE     = 3'd0,
    FLT_UNKNOWN  = 3'd1,
    FLT_BOOL     = 3'd2,
    FLT_ARITH    = 3'd3,
    FLT_STRING   = 3'd4,
    FLT_ARRAY    = 3'd5,
    FLT_COMPARE  = 3'd6
  } fault_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ARITH    = 2'd0,
    CFG_QUOTE    = 2'd1,
    CFG_LIST_SEP = 2'd2,
    CFG_CMD_SEP  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ARITH_W-1:0] arith;
    logic [7:0]         quote;
    logic [7:0]         list_sep;
    logic [7:0]         cmd_sep;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    arith:    48'h255E2A2F2D2B,
    quote:    8'h22,
    list_sep: 8'h2C,
    cmd_sep:  8'h3B
  };

  typedef struct packed {
    kind_e      kind;
    logic [7:0] lexeme;
    logic       byte_valid;
    logic       token_done;
    fault_e     fault;
    logic       expr_done;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } res_list_t;

  function automatic res_t mk_res(kind_e kind, logic [7:0] lexeme, logic bv,
                                  logic done, fault_e flt, logic edone);
    res_t r;
    r.kind       = kind;
    r.lexeme     = lexeme;
    r.byte_valid = bv;
    r.token_done = done;
    r.fault      = flt;
    r.expr_done  = edone;
    return r;
  endfunction

  function automatic res_t mk_fault(fault_e flt, kind_e kind);
    return mk_res(kind, 8'd0, 1'b0, 1'b1, flt, 1'b1);
  endfunction

  function automatic res_list_t push(res_list_t l, res_t r);
    res_list_t o;
    o = l;
    if (l.cnt == 2'd0) begin
      o.r0 = r;
    end else begin
      o.r1 = r;
    end
    o.cnt = l.cnt + 2'd1;
    return o;
  endfunction

endpackage

// ===== sv/rule_expression_tokenizer.sv =====
// Rule expression tokenizer top level: configuration registers, tokenizer
// step and result queue. Uses rexp_pkg, rexp_lex, rexp_resq.
// The result items of an accepted character are queued for the master side.
// Throughput: one character per cycle while the four-entry result
// queue has room for two items; a character yields up to two result items,
// drained one per cycle while m_axis_tready is high. Reset clears the scan
// mode, lookahead, fault skip and queue, and restores the register defaults.
module rule_expression_tokenizer import rexp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_IW-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] in_char
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,   // [7:0] lexeme_byte
  output logic [TUSER_W-1:0] m_axis_tuser,   // [3:0] token_kind, [4] byte_valid,
                                             // [5] token_done, [8:6] fault
  output logic               m_axis_tlast
);

  cfg_t      cfg_q;
  logic      fire;
  res_list_t res;
  res_t      head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ARITH:    cfg_q.arith    <= cfg_data_i[ARITH_W-1:0];
        CFG_QUOTE:    cfg_q.quote    <= cfg_data_i[7:0];
        CFG_LIST_SEP: cfg_q.list_sep <= cfg_data_i[7:0];
        CFG_CMD_SEP:  cfg_q.cmd_sep  <= cfg_data_i[7:0];
      endcase
    end
  end

  assign fire = s_axis_tvalid & s_axis_tready;

  rexp_lex u_lex (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .fire_i  (fire),
    .char_i  (s_axis_tdata),
    .final_i (s_axis_tlast),
    .res_o   (res)
  );

  rexp_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .res_i   (res),
    .room_o  (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = head.lexeme;
  assign m_axis_tuser = {head.fault, head.token_done, head.byte_valid, head.kind};
  assign m_axis_tlast = head.expr_done;

endmodule

// ===== sv/rexp_lex.sv =====
// Tokenizer step: scan mode, one-character lookahead and fault skip state,
// producing up to two result items per accepted character. Uses rexp_pkg.
module rexp_lex import rexp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       fire_i,
  input  logic [7:0] char_i,
  input  logic       final_i,
  output res_list_t  res_o
);

  typedef enum logic [10:0] {
    M_IDLE   = 11'b000_0000_0001,
    M_NUMBER = 11'b000_0000_0010,
    M_IDENT  = 11'b000_0000_0100,
    M_STRING = 11'b000_0000_1000,
    M_ARRAY  = 11'b000_0001_0000,
    M_AMP    = 11'b000_0010_0000,
    M_BAR    = 11'b000_0100_0000,
    M_BANG   = 11'b000_1000_0000,
    M_LT     = 11'b001_0000_0000,
    M_GT     = 11'b010_0000_0000,
    M_EQ     = 11'b100_0000_0000
  } mode_e;

  typedef struct packed {
    logic       emit;
    res_t       r;
    mode_e      mode;
    logic       hv;
    logic [7:0] hc;
    logic       flt;
  } start_t;

  function automatic logic is_ws(logic [7:0] c);
    return c == CH_SPACE || c == CH_CR || c == CH_TAB || c == CH_LF;
  endfunction

  function automatic logic is_dig(logic [7:0] c);
    return c >= CH_D0 && c <= CH_D9;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_alpha(c) || is_dig(c) || c == CH_US;
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return is_dig(c) || c == CH_DOT;
  endfunction

  function automatic logic is_arith(logic [7:0] c, logic [ARITH_W-1:0] ops);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < ARITH_N; i++) begin
      if (ops[8*i +: 8] == c) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic start_t lex_start(logic [7:0] c, logic fin, cfg_t cfg);
    start_t s;
    s.emit = 1'b0;
    s.r    = mk_res(KIND_ARITH, 8'd0, 1'b0, 1'b0, FLT_NONE, 1'b0);
    s.mode = M_IDLE;
    s.hv   = 1'b0;
    s.hc   = c;
    s.flt  = 1'b0;
    if (is_ws(c)) begin
      s.emit = 1'b0;
    end else if (is_arith(c, cfg.arith)) begin
      s.emit = 1'b1;
      if (fin) begin
        s.r   = mk_fault(FLT_ARITH, KIND_ARITH);
        s.flt = 1'b1;
      end else begin
        s.r = mk_res(KIND_ARITH, c, 1'b1, 1'b1, FLT_NONE, 1'b0);
      end
    end else if (c == CH_AMP || c == CH_BAR || c == CH_BANG) begin
      if (fin) begin
        s.emit = 1'b1;
        s.r    = mk_fault(FLT_BOOL, KIND_BOOL);
        s.flt  = 1'b1;
      end else begin
        s.mode = (c == CH_AMP) ? M_AMP : (c == CH_BAR) ? M_BAR : M_BANG;
      end
    end else if (c == CH_LBRK) begin
      if (fin) begin
        s.emit = 1'b1;
        s.r    = mk_fault(FLT_ARRAY, KIND_ARRAY);
        s.flt  = 1'b1;
      end else begin
        s.mode = M_ARRAY;
      end
    end else if (c == cfg.quote) begin
      if (fin) begin
        s.emit = 1'b1;
        s.r    = mk_fault(FLT_STRING, KIND_STRING);
        s.flt  = 1'b1;
      end else begin
        s.mode = M_STRING;
      end
    end else if (is_num(c)) begin
      if (fin) begin
        s.emit = 1'b1;
        s.r    = mk_res(KIND_NUMBER, c, 1'b1, 1'b1, FLT_NONE, 1'b0);
      end else begin
        s.hv   = 1'b1;
        s.mode = M_NUMBER;
      end
    end else if (c == CH_LPAR) begin
      s.emit = 1'b1;
      s.r    = mk_res(KIND_LPAREN, c, 1'b1, 1'b1, FLT_NONE, 1'b0);
    end else if (c == CH_RPAR) begin
      s.emit = 1'b1;
      s.r    = mk_res(KIND_RPAREN, c, 1'b1, 1'b1, FLT_NONE, 1'b0);
    end else if (c == CH_LT || c == CH_GT || c == CH_EQ) begin
      if (fin) begin
        s.emit = 1'b1;
        s.r    = mk_fault(FLT_COMPARE, KIND_COMPARE);
        s.flt  = 1'b1;
      end else begin
        s.mode = (c == CH_LT) ? M_LT : (c == CH_GT) ? M_GT : M_EQ;
      end
    end else if (is_alpha(c) || c == CH_US) begin
      if (fin) begin
        s.emit = 1'b1;
        s.r    = mk_res(KIND_IDENT, c, 1'b1, 1'b1, FLT_NONE, 1'b0);
      end else begin
        s.hv   = 1'b1;
        s.mode = M_IDENT;
      end
    end else if (c == cfg.list_sep || c == cfg.cmd_sep) begin
      s.emit = 1'b1;
      s.r    = mk_res(KIND_SEP, c, 1'b1, 1'b1, FLT_NONE, 1'b0);
    end else begin
      s.emit = 1'b1;
      s.r    = mk_fault(FLT_UNKNOWN, KIND_ARITH);
      s.flt  = 1'b1;
    end
    return s;
  endfunction

  mode_e      mode_q, mode_d;
  logic       hv_q, hv_d;
  logic [7:0] hc_q, hc_d;
  logic       lat_q, lat_d;

  start_t     st;
  res_list_t  res;
  logic       flt;
  logic       do_start;
  kind_e      wk;
  logic       wm;
  kind_e      qk;
  fault_e     qcode;
  logic       closer;
  logic [7:0] want;
  logic [7:0] op;

  assign st   = lex_start(char_i, final_i, cfg_i);
  assign wk   = (mode_q == M_NUMBER) ? KIND_NUMBER : KIND_IDENT;
  assign wm   = (mode_q == M_NUMBER) ? is_num(char_i) : is_word(char_i);
  assign qk   = (mode_q == M_STRING) ? KIND_STRING : KIND_ARRAY;
  assign qcode = (mode_q == M_STRING) ? FLT_STRING : FLT_ARRAY;
  assign closer = (mode_q == M_STRING) ? (char_i == cfg_i.quote) : (char_i == CH_RBRK);
  assign want = (mode_q == M_AMP) ? CH_AMP : CH_BAR;
  assign op   = (mode_q == M_LT) ? CH_LT : CH_GT;

  always_comb begin
    res      = '0;
    mode_d   = M_IDLE;
    hv_d     = hv_q;
    hc_d     = hc_q;
    lat_d    = lat_q;
    flt      = 1'b0;
    do_start = 1'b0;
    if (lat_q) begin
      mode_d = mode_q;
      if (final_i) lat_d = 1'b0;
    end else begin
      unique case (mode_q)
        M_NUMBER, M_IDENT: begin
          if (wm) begin
            if (hv_q) res = push(res, mk_res(wk, hc_q, 1'b1, 1'b0, FLT_NONE, 1'b0));
            hc_d   = char_i;
            hv_d   = 1'b1;
            mode_d = mode_q;
            if (final_i) begin
              res    = push(res, mk_res(wk, char_i, 1'b1, 1'b1, FLT_NONE, 1'b0));
              hv_d   = 1'b0;
              mode_d = M_IDLE;
            end
          end else begin
            res = push(res, mk_res(wk, hv_q ? hc_q : 8'd0, hv_q, 1'b1, FLT_NONE, 1'b0));
            do_start = 1'b1;
          end
        end
        M_STRING, M_ARRAY: begin
          if (closer) begin
            res  = push(res, mk_res(qk, hv_q ? hc_q : 8'd0, hv_q, 1'b1, FLT_NONE, 1'b0));
            hv_d = 1'b0;
          end else if (final_i) begin
            res  = push(res, mk_fault(qcode, qk));
            hv_d = 1'b0;
            flt  = 1'b1;
          end else begin
            if (hv_q) res = push(res, mk_res(qk, hc_q, 1'b1, 1'b0, FLT_NONE, 1'b0));
            hc_d   = char_i;
            hv_d   = 1'b1;
            mode_d = mode_q;
          end
        end
        M_AMP, M_BAR: begin
          hv_d = 1'b0;
          if (char_i == want) begin
            res = push(res, mk_res(KIND_BOOL, want, 1'b1, 1'b0, FLT_NONE, 1'b0));
            res = push(res, mk_res(KIND_BOOL, want, 1'b1, 1'b1, FLT_NONE, 1'b0));
          end else begin
            res = push(res, mk_fault(FLT_BOOL, KIND_BOOL));
            flt = 1'b1;
          end
        end
        M_BANG: begin
          hv_d = 1'b0;
          if (char_i == CH_EQ) begin
            res = push(res, mk_res(KIND_COMPARE, CH_BANG, 1'b1, 1'b0, FLT_NONE, 1'b0));
            res = push(res, mk_res(KIND_COMPARE, CH_EQ, 1'b1, 1'b1, FLT_NONE, 1'b0));
          end else if (char_i == CH_BANG || is_ws(char_i) || is_word(char_i) ||
                       char_i == CH_LPAR) begin
            res = push(res, mk_res(KIND_BOOL, CH_BANG, 1'b1, 1'b1, FLT_NONE, 1'b0));
            do_start = 1'b1;
          end else begin
            res = push(res, mk_fault(FLT_BOOL, KIND_BOOL));
            flt = 1'b1;
          end
        end
        M_LT, M_GT: begin
          hv_d = 1'b0;
          if (char_i == CH_EQ) begin
            res = push(res, mk_res(KIND_COMPARE, op, 1'b1, 1'b0, FLT_NONE, 1'b0));
            res = push(res, mk_res(KIND_COMPARE, CH_EQ, 1'b1, 1'b1, FLT_NONE, 1'b0));
          end else begin
            res = push(res, mk_res(KIND_COMPARE, op, 1'b1, 1'b1, FLT_NONE, 1'b0));
            do_start = 1'b1;
          end
        end
        M_EQ: begin
          hv_d = 1'b0;
          if (char_i == CH_EQ) begin
            res = push(res, mk_res(KIND_COMPARE, CH_EQ, 1'b1, 1'b0, FLT_NONE, 1'b0));
            res = push(res, mk_res(KIND_COMPARE, CH_EQ, 1'b1, 1'b1, FLT_NONE, 1'b0));
          end else begin
            res = push(res, mk_fault(FLT_COMPARE, KIND_COMPARE));
            flt = 1'b1;
          end
        end
        default: begin
          do_start = 1'b1;
        end
      endcase

      if (do_start) begin
        if (st.emit) res = push(res, st.r);
        mode_d = st.mode;
        hv_d   = st.hv;
        hc_d   = st.hc;
        flt    = st.flt;
      end

      if (final_i) begin
        mode_d = M_IDLE;
        hv_d   = 1'b0;
        if (res.cnt == 2'd2) begin
          res.r1.expr_done = 1'b1;
        end else if (res.cnt == 2'd1) begin
          res.r0.expr_done = 1'b1;
        end else begin
          res = push(res, mk_res(KIND_ARITH, 8'd0, 1'b0, 1'b0, FLT_NONE, 1'b1));
        end
      end
      lat_d = flt & ~final_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      hv_q   <= 1'b0;
      hc_q   <= 8'd0;
      lat_q  <= 1'b0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      hv_q   <= hv_d;
      hc_q   <= hc_d;
      lat_q  <= lat_d;
    end
  end

  assign res_o = res;

endmodule

// ===== sv/rexp_resq.sv =====
// Result queue: takes up to two result items per cycle from the tokenizer
// step and hands them out one per cycle while ready_i is high. Uses rexp_pkg.
module rexp_resq import rexp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  res_list_t res_i,
  output logic      room_o,
  output logic      valid_o,
  input  logic      ready_i,
  output res_t      head_o
);

  localparam logic [RQ_AW:0] ROOM_MAX = (RQ_AW+1)'(RQ_DEPTH - MAX_PUSH);

  res_t             mem_q [RQ_DEPTH];
  logic [RQ_AW-1:0] wp_q, wp_d;
  logic [RQ_AW-1:0] rp_q, rp_d;
  logic [RQ_AW:0]   cnt_q, cnt_d;
  logic [RQ_AW:0]   n_push;
  logic             pop;
  logic [RQ_AW-1:0] wp_nxt;

  assign n_push = push_i ? (RQ_AW+1)'(res_i.cnt) : '0;
  assign pop    = valid_o & ready_i;
  assign wp_nxt = wp_q + RQ_AW'(1);
  assign wp_d   = wp_q + n_push[RQ_AW-1:0];
  assign rp_d   = pop ? rp_q + RQ_AW'(1) : rp_q;
  assign cnt_d  = cnt_q + n_push - (RQ_AW+1)'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i && res_i.cnt != 2'd0) mem_q[wp_q] <= res_i.r0;
    if (push_i && res_i.cnt == 2'd2) mem_q[wp_nxt] <= res_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  assign valid_o = cnt_q != '0;
  assign room_o  = cnt_q <= ROOM_MAX;
  assign head_o  = mem_q[rp_q];

endmodule
